FILE: src/slbb_pkg.sv
`timescale 1ns / 1ps

package slbb_pkg;

    // timer and field widths
    localparam int TIMER_BITS = 32;
    localparam int DT_W       = 16;
    localparam int PERIOD_W   = 10;
    localparam int DUTY_W     = 7;
    localparam int BREATH_W   = 14;
    localparam int PWM_W      = 7;
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 14;

    // derived threshold widths, sized for the largest register values
    localparam int ON_W      = 20;
    localparam int OFF_W     = 21;
    localparam int FULL_W    = 24;
    localparam int PWM_THR_W = 17;
    localparam int CMP_W     = (TIMER_BITS > FULL_W) ? TIMER_BITS : FULL_W;

    // breathing segments
    localparam int SEG_N = 10;
    localparam int SEG_W = 4;

    // unit conversions
    localparam int US_PER_MS     = 1000;
    localparam int US_PER_MS_PCT = 10;
    localparam int SEG_US_PER_MS = 100;
    localparam int MIN_ON_DUTY   = 5;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_DUTY   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_BREATH      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_PWM         = CFG_IDX_W'(3);

    // register reset values
    localparam logic [PERIOD_W-1:0] RST_INIT_PERIOD = PERIOD_W'(200);
    localparam logic [DUTY_W-1:0]   RST_INIT_DUTY   = DUTY_W'(50);
    localparam logic [BREATH_W-1:0] RST_BREATH      = BREATH_W'(600);
    localparam logic [PWM_W-1:0]    RST_PWM         = PWM_W'(25);

    // operating mode, one-hot
    typedef enum logic [2:0] {
        MODE_INIT   = 3'b001,
        MODE_NORMAL = 3'b010,
        MODE_LOST   = 3'b100
    } t_mode;

    // mode codes as shown on the result
    localparam logic [1:0] MODE_CODE_INIT   = 2'd0;
    localparam logic [1:0] MODE_CODE_NORMAL = 2'd1;
    localparam logic [1:0] MODE_CODE_LOST   = 2'd2;

    // led colours: bit0 red, bit1 green, bit2 blue
    typedef logic [2:0] t_led;
    localparam t_led LED_OFF    = 3'b000;
    localparam t_led LED_WHITE  = 3'b111;
    localparam t_led LED_BLUE   = 3'b100;
    localparam t_led LED_YELLOW = 3'b011;

    typedef struct packed {
        logic [DT_W-1:0] dt_us;
        logic            imu_ready;
        logic            rc_fresh;
    } t_item;

    typedef struct packed {
        logic [1:0] mode;
        logic       red;
        logic       green;
        logic       blue;
        logic       link_valid;
        logic       start_tune;
    } t_res;

    // precomputed thresholds in microseconds
    typedef struct packed {
        logic [ON_W-1:0]                       blink_on;
        logic [OFF_W-1:0]                      blink_off;
        logic                                  blink_duty_ok;
        logic [FULL_W-1:0]                     breath_full;
        logic [SEG_N-2:0][FULL_W-1:0]          seg_thr;
        logic [PWM_THR_W-1:0]                  pwm_on;
        logic [SEG_N-1:0][PWM_THR_W-1:0]       pwm_off;
    } t_thr;

    function automatic logic [1:0] mode_code(t_mode m);
        logic [1:0] c;
        case (m)
            MODE_INIT:   c = MODE_CODE_INIT;
            MODE_NORMAL: c = MODE_CODE_NORMAL;
            MODE_LOST:   c = MODE_CODE_LOST;
            default:     c = MODE_CODE_INIT;
        endcase
        return c;
    endfunction

    // breathing duty per segment, percent
    function automatic logic [DUTY_W-1:0] duty_pct(logic [SEG_W-1:0] seg);
        logic [DUTY_W-1:0] d;
        case (seg)
            4'd0:    d = 7'd0;
            4'd1:    d = 7'd20;
            4'd2:    d = 7'd40;
            4'd3:    d = 7'd60;
            4'd4:    d = 7'd80;
            4'd5:    d = 7'd100;
            4'd6:    d = 7'd90;
            4'd7:    d = 7'd60;
            4'd8:    d = 7'd40;
            default: d = 7'd0;
        endcase
        return d;
    endfunction

    // saturating timer add
    function automatic logic [TIMER_BITS-1:0] sat_add(logic [TIMER_BITS-1:0] t,
                                                      logic [DT_W-1:0] dt);
        logic [TIMER_BITS:0] s;
        s = {1'b0, t} + (TIMER_BITS + 1)'(dt);
        return s[TIMER_BITS] ? {TIMER_BITS{1'b1}} : s[TIMER_BITS-1:0];
    endfunction

endpackage

FILE: src/slbb_in_if.sv
`timescale 1ns / 1ps

interface slbb_in_if;
    logic                        valid;
    logic                        ready;
    logic [slbb_pkg::DT_W-1:0]   dt_us;
    logic                        imu_ready;
    logic                        rc_fresh;

    modport source (output valid, output dt_us, output imu_ready, output rc_fresh,
                    input ready);
    modport sink   (input valid, input dt_us, input imu_ready, input rc_fresh,
                    output ready);
endinterface

FILE: src/slbb_out_if.sv
`timescale 1ns / 1ps

interface slbb_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] mode;
    logic       red;
    logic       green;
    logic       blue;
    logic       link_valid;
    logic       start_tune;

    modport source (output valid, output mode, output red, output green, output blue,
                    output link_valid, output start_tune, input ready);
    modport sink   (input valid, input mode, input red, input green, input blue,
                    input link_valid, input start_tune, output ready);
endinterface

FILE: src/slbb_cfg.sv
`timescale 1ns / 1ps

module slbb_cfg (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [slbb_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [slbb_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output slbb_pkg::t_thr                      o_thr
);

    logic [slbb_pkg::PERIOD_W-1:0] r_period;
    logic [slbb_pkg::DUTY_W-1:0]   r_duty;
    logic [slbb_pkg::BREATH_W-1:0] r_breath;
    logic [slbb_pkg::PWM_W-1:0]    r_pwm;
    slbb_pkg::t_thr                r_thr;
    slbb_pkg::t_thr                n_thr;

    // register writes, out-of-range indexes ignored
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= slbb_pkg::RST_INIT_PERIOD;
            r_duty   <= slbb_pkg::RST_INIT_DUTY;
            r_breath <= slbb_pkg::RST_BREATH;
            r_pwm    <= slbb_pkg::RST_PWM;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                slbb_pkg::CFG_INIT_PERIOD: r_period <= i_cfg_data[slbb_pkg::PERIOD_W-1:0];
                slbb_pkg::CFG_INIT_DUTY:   r_duty   <= i_cfg_data[slbb_pkg::DUTY_W-1:0];
                slbb_pkg::CFG_BREATH:      r_breath <= i_cfg_data[slbb_pkg::BREATH_W-1:0];
                slbb_pkg::CFG_PWM:         r_pwm    <= i_cfg_data[slbb_pkg::PWM_W-1:0];
                default: ;
            endcase
        end
    end

    // thresholds in microseconds, recomputed from the registers
    always_comb begin
        n_thr.blink_on  = slbb_pkg::ON_W'(r_period) * slbb_pkg::ON_W'(slbb_pkg::US_PER_MS);
        n_thr.blink_off = slbb_pkg::OFF_W'(r_period) * slbb_pkg::OFF_W'(r_duty)
                        * slbb_pkg::OFF_W'(slbb_pkg::US_PER_MS_PCT);
        n_thr.blink_duty_ok = (r_duty > slbb_pkg::DUTY_W'(slbb_pkg::MIN_ON_DUTY));
        n_thr.breath_full   = slbb_pkg::FULL_W'(r_breath)
                            * slbb_pkg::FULL_W'(slbb_pkg::US_PER_MS);
        for (int k = 0; k < slbb_pkg::SEG_N - 1; k++) begin
            n_thr.seg_thr[k] = slbb_pkg::FULL_W'(r_breath)
                             * slbb_pkg::FULL_W'(slbb_pkg::SEG_US_PER_MS * (k + 1));
        end
        n_thr.pwm_on = slbb_pkg::PWM_THR_W'(r_pwm) * slbb_pkg::PWM_THR_W'(slbb_pkg::US_PER_MS);
        for (int k = 0; k < slbb_pkg::SEG_N; k++) begin
            n_thr.pwm_off[k] = slbb_pkg::PWM_THR_W'(r_pwm)
                             * slbb_pkg::PWM_THR_W'(slbb_pkg::US_PER_MS_PCT)
                             * slbb_pkg::PWM_THR_W'(slbb_pkg::duty_pct(slbb_pkg::SEG_W'(k)));
        end
    end

    always_ff @(posedge i_clk) begin
        r_thr <= n_thr;
    end

    assign o_thr = r_thr;

endmodule

FILE: src/slbb_core.sv
`timescale 1ns / 1ps

module slbb_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_fire,
    input  slbb_pkg::t_item i_item,
    input  slbb_pkg::t_thr  i_thr,
    output slbb_pkg::t_res  o_res
);

    slbb_pkg::t_mode                 r_mode;
    slbb_pkg::t_mode                 n_mode;
    logic [slbb_pkg::TIMER_BITS-1:0] r_blink;
    logic [slbb_pkg::TIMER_BITS-1:0] n_blink;
    logic [slbb_pkg::TIMER_BITS-1:0] r_breath;
    logic [slbb_pkg::TIMER_BITS-1:0] n_breath;
    slbb_pkg::t_led                  r_led;
    slbb_pkg::t_led                  n_led;

    logic [slbb_pkg::SEG_N-2:0]      seg_hit;
    logic [slbb_pkg::SEG_W-1:0]      seg;
    logic [slbb_pkg::CMP_W-1:0]      blink_cmp;
    logic [slbb_pkg::CMP_W-1:0]      breath_cmp;
    logic [slbb_pkg::CMP_W-1:0]      on_thr;
    logic [slbb_pkg::CMP_W-1:0]      off_thr;
    logic                            duty_ok;
    logic                            run_blink;
    slbb_pkg::t_led                  color;
    logic                            tune;

    assign blink_cmp  = slbb_pkg::CMP_W'(r_blink);
    assign breath_cmp = slbb_pkg::CMP_W'(r_breath);

    // mode transitions in fixed order
    always_comb begin
        n_mode = r_mode;
        if (n_mode == slbb_pkg::MODE_INIT && i_item.imu_ready) n_mode = slbb_pkg::MODE_NORMAL;
        if (n_mode == slbb_pkg::MODE_NORMAL && !i_item.rc_fresh) n_mode = slbb_pkg::MODE_LOST;
        if (n_mode == slbb_pkg::MODE_LOST && i_item.rc_fresh) n_mode = slbb_pkg::MODE_NORMAL;
    end

    // breathing segment from parallel compares against the boundaries
    always_comb begin
        for (int k = 0; k < slbb_pkg::SEG_N - 1; k++) begin
            seg_hit[k] = (breath_cmp >= slbb_pkg::CMP_W'(i_thr.seg_thr[k]));
        end
        seg = slbb_pkg::SEG_W'($countones(seg_hit));
    end

    // blink source selection
    always_comb begin
        if (n_mode == slbb_pkg::MODE_INIT) begin
            color     = slbb_pkg::LED_WHITE;
            on_thr    = slbb_pkg::CMP_W'(i_thr.blink_on);
            off_thr   = slbb_pkg::CMP_W'(i_thr.blink_off);
            duty_ok   = i_thr.blink_duty_ok;
            run_blink = 1'b1;
        end else begin
            color     = (n_mode == slbb_pkg::MODE_NORMAL) ? slbb_pkg::LED_BLUE
                                                          : slbb_pkg::LED_YELLOW;
            on_thr    = slbb_pkg::CMP_W'(i_thr.pwm_on);
            off_thr   = slbb_pkg::CMP_W'(i_thr.pwm_off[seg]);
            duty_ok   = (slbb_pkg::duty_pct(seg) > slbb_pkg::DUTY_W'(slbb_pkg::MIN_ON_DUTY));
            run_blink = (breath_cmp < slbb_pkg::CMP_W'(i_thr.breath_full));
        end
    end

    // blink, breath and led update for one tick
    always_comb begin
        n_led    = r_led;
        n_blink  = r_blink;
        n_breath = r_breath;
        if (run_blink) begin
            if (blink_cmp >= off_thr) n_led = slbb_pkg::LED_OFF;
            if (blink_cmp >= on_thr && duty_ok) begin
                n_led   = color;
                n_blink = '0;
            end
            n_blink = slbb_pkg::sat_add(n_blink, i_item.dt_us);
        end
        if (n_mode != slbb_pkg::MODE_INIT) begin
            if (!run_blink) n_breath = '0;
            n_breath = slbb_pkg::sat_add(n_breath, i_item.dt_us);
        end
        if (n_mode != r_mode) n_led = slbb_pkg::LED_OFF;
    end

    assign tune = (r_mode != slbb_pkg::MODE_NORMAL) && (n_mode == slbb_pkg::MODE_NORMAL);

    // state advances once per request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode   <= slbb_pkg::MODE_INIT;
            r_blink  <= '0;
            r_breath <= '0;
            r_led    <= slbb_pkg::LED_OFF;
        end else if (i_fire) begin
            r_mode   <= n_mode;
            r_blink  <= n_blink;
            r_breath <= n_breath;
            r_led    <= n_led;
        end
    end

    assign o_res.mode       = slbb_pkg::mode_code(n_mode);
    assign o_res.red        = n_led[0];
    assign o_res.green      = n_led[1];
    assign o_res.blue       = n_led[2];
    assign o_res.link_valid = i_item.rc_fresh;
    assign o_res.start_tune = tune;

endmodule

FILE: src/status_led_blink_breath_sequencer_unit.sv
`timescale 1ns / 1ps

// Status LED blink / breath sequencer.
// i_in carries one tick per request: elapsed microseconds, the sensor-ready
// flag and the remote-link-fresh flag. o_out returns exactly one result per
// tick: mode code, red/green/blue channels, link flag and a start-tune pulse.
// Configuration is a plain write port (i_cfg_we, i_cfg_idx, i_cfg_data);
// writes must come only while no tick is in flight, indexes above 3 are dropped.
// A tick accepted into the input register passes through the core into the result
// register, which drives o_out (input register, then result register).
// Throughput: one tick per cycle while the receiver takes results; the mode,
// blink and breath update is a single pass of compare logic from the state
// registers back into them. Thresholds in microseconds are recomputed into
// registers after a configuration write.
// Reset (synchronous, active low) restores register defaults, initialising
// mode, cleared timers and the LED off, and empties both pipeline registers.
// When the receiver stalls the result holds, one more tick is taken into the
// input register, and then i_in.ready drops until the result is taken.
module status_led_blink_breath_sequencer_unit (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    slbb_in_if.sink                         i_in,
    slbb_out_if.source                      o_out,
    input  logic                            i_cfg_we,
    input  logic [slbb_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [slbb_pkg::CFG_DATA_W-1:0] i_cfg_data
);

    slbb_pkg::t_thr  thr;
    slbb_pkg::t_item r_item;
    logic            r_in_vld;
    slbb_pkg::t_res  res;
    slbb_pkg::t_res  r_res;
    logic            r_out_vld;
    logic            fire;

    slbb_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_thr      (thr)
    );

    // stage advances when the result register is free or being emptied
    assign fire       = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = i_rst_n && (!r_in_vld || fire);

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_in.ready) begin
            r_in_vld <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.dt_us     <= i_in.dt_us;
            r_item.imu_ready <= i_in.imu_ready;
            r_item.rc_fresh  <= i_in.rc_fresh;
        end
    end

    slbb_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (fire),
        .i_item  (r_item),
        .i_thr   (thr),
        .o_res   (res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (fire) begin
            r_out_vld <= 1'b1;
        end else if (o_out.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_res <= res;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.mode       = r_res.mode;
    assign o_out.red        = r_res.red;
    assign o_out.green      = r_res.green;
    assign o_out.blue       = r_res.blue;
    assign o_out.link_valid = r_res.link_valid;
    assign o_out.start_tune = r_res.start_tune;

endmodule

FILE: src/slbb_checker.sv
`timescale 1ns / 1ps

module slbb_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [1:0] i_mode,
    input  logic       i_red,
    input  logic       i_green,
    input  logic       i_blue,
    input  logic       i_link_valid,
    input  logic       i_start_tune
);

    // results are cleared by reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // start-tune only in normal mode
    a_tune_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_start_tune |-> i_mode == slbb_pkg::MODE_CODE_NORMAL)
        else $error("start-tune outside normal mode");

    // a mode change leaves the led dark
    a_tune_dark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_start_tune |-> !i_red && !i_green && !i_blue)
        else $error("led lit on mode change");

    // once past initialising, mode follows the link flag
    a_link_mode: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_mode != slbb_pkg::MODE_CODE_INIT
        |-> i_link_valid == (i_mode == slbb_pkg::MODE_CODE_NORMAL))
        else $error("mode disagrees with link flag");

endmodule

bind status_led_blink_breath_sequencer_unit slbb_checker u_slbb_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_out_valid  (o_out.valid),
    .i_out_ready  (o_out.ready),
    .i_mode       (o_out.mode),
    .i_red        (o_out.red),
    .i_green      (o_out.green),
    .i_blue       (o_out.blue),
    .i_link_valid (o_out.link_valid),
    .i_start_tune (o_out.start_tune)
);

FILE: tb/sv/tb_status_led_blink_breath_sequencer_unit.sv
`timescale 1ns / 1ps

module tb_status_led_blink_breath_sequencer_unit;
    import slbb_pkg::*;

    localparam logic [TIMER_BITS-1:0] TIMER_MAX = {TIMER_BITS{1'b1}};
    // full-scale ticks that carry the blink timer past the longest period
    localparam int SAT_TICKS   = 20;
    localparam int HOLD_AT     = 60;
    localparam int HOLD_CYCLES = 400;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    slbb_in_if  tick_if ();
    slbb_out_if led_if ();

    status_led_blink_breath_sequencer_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (tick_if),
        .o_out      (led_if),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // predictor copy of the registers
    logic [PERIOD_W-1:0] cfg_blink_period  = RST_INIT_PERIOD;
    logic [DUTY_W-1:0]   cfg_blink_duty    = RST_INIT_DUTY;
    logic [BREATH_W-1:0] cfg_breath_period = RST_BREATH;
    logic [PWM_W-1:0]    cfg_pwm_cycle     = RST_PWM;

    // predictor copy of the sequencer state
    logic [1:0]            led_mode   = MODE_CODE_INIT;
    logic [TIMER_BITS-1:0] blink_tmr  = '0;
    logic [TIMER_BITS-1:0] breath_tmr = '0;
    t_led                  led_on     = LED_OFF;
    int unsigned breath_duty_tbl [SEG_N] = '{0, 20, 40, 60, 80, 100, 90, 60, 40, 0};

    t_item tick_q[$];
    t_item tick_cur;
    t_res  led_exp_q[$];
    int    ticks_pushed = 0;
    int    ticks_taken  = 0;
    int    tick_gap     = 0;
    int    stall_left   = 0;
    int    results_seen = 0;
    int    err_count    = 0;
    bit    idle_on      = 1'b1;
    bit    link_up      = 1'b1;

    function automatic logic [TIMER_BITS-1:0] timer_add(logic [TIMER_BITS-1:0] t,
                                                        logic [DT_W-1:0] dt);
        if (t > TIMER_MAX - TIMER_BITS'(dt))
            return TIMER_MAX;
        return t + TIMER_BITS'(dt);
    endfunction

    // one blink step on the shared timer, thresholds in microseconds
    function automatic void blink_step(t_led colour, longint unsigned per_ms,
                                       longint unsigned duty, logic [DT_W-1:0] dt);
        longint unsigned t;
        t = blink_tmr;
        if (t >= per_ms * US_PER_MS_PCT * duty)
            led_on = LED_OFF;
        if (t >= per_ms * US_PER_MS && duty > MIN_ON_DUTY) begin
            led_on    = colour;
            blink_tmr = '0;
        end
        blink_tmr = timer_add(blink_tmr, dt);
    endfunction

    // breathing: wrap at the full period, else pwm blink at the segment duty
    function automatic void breath_step(t_led colour, logic [DT_W-1:0] dt);
        longint unsigned per_ms;
        longint unsigned t;
        longint unsigned seg;
        per_ms = cfg_breath_period;
        t      = breath_tmr;
        if (t >= per_ms * US_PER_MS) begin
            breath_tmr = '0;
        end else begin
            seg = t / (per_ms * SEG_US_PER_MS);
            if (seg > SEG_N - 1)
                seg = SEG_N - 1;
            blink_step(colour, cfg_pwm_cycle, breath_duty_tbl[seg], dt);
        end
        breath_tmr = timer_add(breath_tmr, dt);
    endfunction

    // mode walk in fixed order, then the led update for the resulting mode
    function automatic t_res next_led_state(t_item tk);
        logic [1:0] was;
        t_res       r;
        was = led_mode;
        if (led_mode == MODE_CODE_INIT && tk.imu_ready)
            led_mode = MODE_CODE_NORMAL;
        if (led_mode == MODE_CODE_NORMAL && !tk.rc_fresh)
            led_mode = MODE_CODE_LOST;
        if (led_mode == MODE_CODE_LOST && tk.rc_fresh)
            led_mode = MODE_CODE_NORMAL;
        case (led_mode)
            MODE_CODE_INIT:   blink_step(LED_WHITE, cfg_blink_period, cfg_blink_duty,
                                         tk.dt_us);
            MODE_CODE_NORMAL: breath_step(LED_BLUE, tk.dt_us);
            default:          breath_step(LED_YELLOW, tk.dt_us);
        endcase
        r.start_tune = (was == MODE_CODE_INIT || was == MODE_CODE_LOST) &&
                       led_mode == MODE_CODE_NORMAL;
        if (led_mode != was)
            led_on = LED_OFF;
        r.mode       = led_mode;
        r.red        = led_on[0];
        r.green      = led_on[1];
        r.blue       = led_on[2];
        r.link_valid = tk.rc_fresh;
        return r;
    endfunction

    function automatic int pick_pause();
        if ($urandom_range(0, 9) < 9)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [DT_W-1:0] pick_dt();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 5)
            return '0;
        if (r < 10)
            return {DT_W{1'b1}};
        if (r < 15)
            return DT_W'($urandom_range(1, 15));
        if (r < 50)
            return DT_W'($urandom_range(500, 8000));
        if (r < 80)
            return DT_W'($urandom_range(0, 65535));
        return DT_W'($urandom_range(8000, 30000));
    endfunction

    // random tick; once out of initialisation the link mostly holds steady
    function automatic t_item make_tick(bit may_leave_init);
        t_item tk;
        tk.dt_us = pick_dt();
        if (may_leave_init) begin
            tk.imu_ready = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 99) < 4)
                link_up = ~link_up;
            tk.rc_fresh = link_up;
            if ($urandom_range(0, 99) < 3)
                tk.rc_fresh = ~link_up;
        end else begin
            tk.imu_ready = 1'b0;
            tk.rc_fresh  = 1'($urandom_range(0, 1));
        end
        return tk;
    endfunction

    task automatic field_check(input string name, input logic [1:0] want,
                               input logic [1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            err_count++;
        end
    endtask

    task automatic check_led(input t_res got);
        t_res want;
        if (led_exp_q.size() == 0) begin
            $error("result with no request pending: mode %0d", got.mode);
            err_count++;
        end else begin
            want = led_exp_q.pop_front();
            field_check("mode", want.mode, got.mode);
            field_check("red", 2'(want.red), 2'(got.red));
            field_check("green", 2'(want.green), 2'(got.green));
            field_check("blue", 2'(want.blue), 2'(got.blue));
            field_check("link_valid", 2'(want.link_valid), 2'(got.link_valid));
            field_check("start_tune", 2'(want.start_tune), 2'(got.start_tune));
        end
    endtask

    // driver: predict on acceptance, then offer the next request after a gap
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            if (tick_if.valid && tick_if.ready) begin
                led_exp_q.push_back(next_led_state(tick_cur));
                ticks_taken++;
            end
            if (!tick_if.valid || tick_if.ready) begin
                if (tick_gap > 0) begin
                    tick_gap--;
                    tick_if.valid <= 1'b0;
                end else if (tick_q.size() > 0) begin
                    tick_cur = tick_q.pop_front();
                    tick_if.valid     <= 1'b1;
                    tick_if.dt_us     <= tick_cur.dt_us;
                    tick_if.imu_ready <= tick_cur.imu_ready;
                    tick_if.rc_fresh  <= tick_cur.rc_fresh;
                    tick_gap = (idle_on && $urandom_range(0, 99) < 30) ? pick_pause() : 0;
                end else begin
                    tick_if.valid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result, random stalls and one long hold-off
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            led_if.ready <= 1'b0;
        end else begin
            if (led_if.valid && led_if.ready) begin
                results_seen++;
                check_led({led_if.mode, led_if.red, led_if.green, led_if.blue,
                           led_if.link_valid, led_if.start_tune});
                if (results_seen == HOLD_AT)
                    stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0) begin
                stall_left--;
                led_if.ready <= 1'b0;
            end else begin
                led_if.ready <= 1'b1;
                if (idle_on && $urandom_range(0, 99) < 15)
                    stall_left = pick_pause();
            end
        end
    end

    task automatic queue_tick(input logic [DT_W-1:0] dt, input logic imu, input logic rc);
        t_item tk;
        tk.dt_us     = dt;
        tk.imu_ready = imu;
        tk.rc_fresh  = rc;
        tick_q.push_back(tk);
        ticks_pushed++;
    endtask

    task automatic queue_random(input int n, input bit may_leave_init);
        repeat (n) begin
            tick_q.push_back(make_tick(may_leave_init));
            ticks_pushed++;
        end
    endtask

    // wait for every request to come back, then let the pipeline settle
    task automatic wait_quiet();
        while (ticks_taken != ticks_pushed || led_exp_q.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            CFG_INIT_PERIOD: cfg_blink_period  = val[PERIOD_W-1:0];
            CFG_INIT_DUTY:   cfg_blink_duty    = val[DUTY_W-1:0];
            CFG_BREATH:      cfg_breath_period = val[BREATH_W-1:0];
            CFG_PWM:         cfg_pwm_cycle     = val[PWM_W-1:0];
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // write to an index past the register file, must be dropped
    task automatic write_unused();
        write_reg(CFG_IDX_W'($urandom_range(int'(CFG_PWM) + 1, (1 << CFG_IDX_W) - 1)),
                  CFG_DATA_W'($urandom));
    endtask

    task automatic breath_phase(input logic [CFG_DATA_W-1:0] per,
                                input logic [CFG_DATA_W-1:0] pwm, input int n);
        write_reg(CFG_BREATH, per);
        write_reg(CFG_PWM, pwm);
        write_unused();
        queue_random(n, 1'b1);
        wait_quiet();
    endtask

    // stimulus
    initial begin
        tick_if.valid     = 1'b0;
        tick_if.dt_us     = '0;
        tick_if.imu_ready = 1'b0;
        tick_if.rc_fresh  = 1'b0;
        led_if.ready      = 1'b0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // initialising blink at reset settings, timer climbing to the first flash
        repeat (5) queue_tick({DT_W{1'b1}}, 1'b0, 1'b1);
        queue_tick('0, 1'b0, 1'b0);
        queue_tick(16'd1, 1'b0, 1'b1);
        queue_tick(16'h8000, 1'b0, 1'b0);
        queue_random(60, 1'b0);
        wait_quiet();

        // shortest period at full duty, on and off thresholds coincide
        write_reg(CFG_INIT_PERIOD, 14'd1);
        write_reg(CFG_INIT_DUTY, 14'd100);
        queue_tick(16'd999, 1'b0, 1'b1);
        queue_tick(16'd1, 1'b0, 1'b0);
        queue_tick('0, 1'b0, 1'b1);
        queue_tick(16'd1000, 1'b0, 1'b1);
        wait_quiet();

        // zero period and duty past a full period, upper data bits dropped
        write_reg(CFG_INIT_PERIOD, 14'h3C00);
        write_reg(CFG_INIT_DUTY, 14'h3FFF);
        queue_tick('0, 1'b0, 1'b0);
        queue_tick({DT_W{1'b1}}, 1'b0, 1'b1);
        queue_random(30, 1'b0);
        wait_quiet();

        // longest period, duty just over the flash floor
        write_reg(CFG_INIT_PERIOD, 14'h03FF);
        write_reg(CFG_INIT_DUTY, 14'd6);
        queue_random(40, 1'b0);
        wait_quiet();

        // duty at the floor never flashes
        write_reg(CFG_INIT_PERIOD, 14'd1);
        write_reg(CFG_INIT_DUTY, CFG_DATA_W'(MIN_ON_DUTY));
        queue_random(20, 1'b0);
        wait_quiet();

        repeat (3) begin
            write_reg(CFG_INIT_PERIOD, CFG_DATA_W'($urandom_range(1, 1000)));
            write_reg(CFG_INIT_DUTY, CFG_DATA_W'($urandom_range(0, 100)));
            write_unused();
            queue_random(40, 1'b0);
            wait_quiet();
        end

        // zero duty never flashes, so the timer keeps climbing
        write_reg(CFG_INIT_PERIOD, 14'd1000);
        write_reg(CFG_INIT_DUTY, '0);
        idle_on = 1'b0;
        repeat (SAT_TICKS) queue_tick({DT_W{1'b1}}, 1'b0, 1'($urandom_range(0, 1)));
        wait_quiet();
        idle_on = 1'b1;

        // timer past the period crosses both thresholds on the first tick
        write_reg(CFG_INIT_DUTY, 14'd100);
        queue_random(20, 1'b0);
        wait_quiet();

        // leaving initialisation with the link down goes through normal into lost
        queue_tick(16'd2000, 1'b1, 1'b0);
        queue_tick(16'd2000, 1'b0, 1'b1);
        queue_tick(16'd2000, 1'b1, 1'b1);
        queue_tick(16'd2000, 1'b0, 1'b0);
        queue_tick(16'd2000, 1'b1, 1'b0);
        queue_tick(16'd2000, 1'b0, 1'b1);
        queue_random(100, 1'b1);
        wait_quiet();

        // breathing over extreme and random settings
        breath_phase(14'd10, 14'd1, 80);
        breath_phase(14'd0, 14'd25, 30);
        breath_phase(14'h3FFF, 14'h3FFF, 80);
        breath_phase(14'd1, 14'd0, 50);
        breath_phase(14'd10000, 14'd100, 60);
        repeat (2)
            breath_phase(CFG_DATA_W'($urandom_range(10, 1000)),
                         CFG_DATA_W'($urandom_range(1, 50)), 80);
        breath_phase(CFG_DATA_W'(RST_BREATH), CFG_DATA_W'(RST_PWM), 80);

        if (err_count == 0 && led_exp_q.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

    // watchdog
    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
